[rtl/hjc_pkg.sv]
// Shared types and codes of the handwheel jog controller.
package hjc_pkg;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_ACCEPT = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;
   localparam logic [1:0] MODE_TOGGLE = 2'd3;

   localparam logic [1:0] PHASE_OFF          = 2'd0;
   localparam logic [1:0] PHASE_ON           = 2'd1;
   localparam logic [1:0] PHASE_WAIT_RELEASE = 2'd2;
   localparam logic [1:0] PHASE_RELEASED     = 2'd3;

   localparam logic signed [16:0] TOTAL_LIMIT = 17'sd32767;

   localparam int REQ_DATA_W = 12;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_INDEX_W = 4;

   // Packed so that the first field sits in the highest bits.
   typedef struct packed {
      logic              x_busy;
      logic              z_busy;
      logic              display_active;
      logic signed [7:0] encoder_delta;
      logic              button_level;
   } req_data_type;

   typedef struct packed {
      logic        active_axis;
      logic [1:0]  active_size;
      logic [1:0]  pending_size;
      logic        size_change_shown;
      logic [30:0] move_steps;
      logic        move_reverse;
      logic        move_axis;
      logic        move_valid;
   } rsp_data_type;

   typedef struct packed {
      logic [1:0]         phase;
      logic [1:0]         pending_index;
      logic [1:0]         current_index;
      logic               axis_select;
      logic signed [15:0] pulse_total;
   } hjc_state_type;

endpackage

[rtl/hjc_step.sv]
// Next-state and result logic for one item of the jog controller.
module hjc_step #(
   parameter int DEBOUNCE_TICKS = 20,
   parameter int CNT_W = 5
) (
   input  logic [1:0]                  mode,
   input  hjc_pkg::req_data_type       req,
   input  hjc_pkg::hjc_state_type      state,
   input  logic [CNT_W-1:0]            cnt,
   input  logic [15:0]                 coeff,
   output hjc_pkg::hjc_state_type      state_next,
   output logic [CNT_W-1:0]            cnt_next,
   output hjc_pkg::rsp_data_type       rsp
);
   import hjc_pkg::*;

   logic [CNT_W-1:0]   cnt_dec;
   logic               expired;
   logic               pressed;
   logic               busy;
   logic signed [16:0] sum_raw;
   logic signed [16:0] sum_sat;
   logic [14:0]        mag;
   logic [30:0]        product;

   assign cnt_dec = (cnt != '0) ? cnt - CNT_W'(1) : cnt;
   assign expired = (cnt_dec == '0);
   assign pressed = ~req.button_level;
   assign busy    = req.z_busy | req.x_busy;

   assign sum_raw = {state.pulse_total[15], state.pulse_total}
                  + {{9{req.encoder_delta[7]}}, req.encoder_delta};

   always_comb begin
      if (sum_raw > TOTAL_LIMIT) begin
         sum_sat = TOTAL_LIMIT;
      end else if (sum_raw < -TOTAL_LIMIT) begin
         sum_sat = -TOTAL_LIMIT;
      end else begin
         sum_sat = sum_raw;
      end
   end

   // The saturated sum is within 15 bits of magnitude.
   assign mag     = sum_sat[16] ? 15'(-sum_sat) : sum_sat[14:0];
   assign product = {15'd0, coeff} * {16'd0, mag};

   always_comb begin
      state_next = state;
      cnt_next   = cnt;
      rsp        = '0;
      case (mode)
         MODE_TICK: begin
            cnt_next = cnt_dec;
            if (req.display_active) begin
               case (state.phase)
                  PHASE_OFF: begin
                     if (pressed) begin
                        state_next.phase = PHASE_ON;
                        cnt_next         = CNT_W'(DEBOUNCE_TICKS);
                     end
                  end
                  PHASE_ON: begin
                     if (expired && pressed) begin
                        state_next.pending_index = state.pending_index + 2'd1;
                        rsp.size_change_shown    = 1'b1;
                        state_next.phase         = PHASE_WAIT_RELEASE;
                     end
                  end
                  PHASE_WAIT_RELEASE: begin
                     if (!pressed) begin
                        state_next.phase = PHASE_RELEASED;
                        cnt_next         = CNT_W'(DEBOUNCE_TICKS);
                     end
                  end
                  default: begin
                     if (expired) begin
                        state_next.phase = pressed ? PHASE_WAIT_RELEASE : PHASE_OFF;
                     end
                  end
               endcase

               if (req.encoder_delta != '0) begin
                  if (busy) begin
                     state_next.pulse_total = sum_sat[15:0];
                  end else begin
                     state_next.pulse_total = '0;
                     if (sum_sat != '0) begin
                        rsp.move_valid   = 1'b1;
                        rsp.move_axis    = state.axis_select;
                        rsp.move_reverse = sum_sat[16];
                        rsp.move_steps   = product;
                     end
                  end
               end
            end
         end
         MODE_ACCEPT: begin
            state_next.current_index = state.pending_index;
         end
         MODE_CANCEL: begin
            state_next.pending_index = state.current_index;
         end
         default: begin
            state_next.axis_select   = ~state.axis_select;
            state_next.pending_index = '0;
            state_next.current_index = '0;
         end
      endcase
      rsp.pending_size = state_next.pending_index;
      rsp.active_size  = state_next.current_index;
      rsp.active_axis  = state_next.axis_select;
   end

endmodule

[rtl/handwheel_jog_controller.sv]
// Handwheel jog controller: debounced size select, pulse totals and move requests.
//
// The req channel carries one item per tick or command: tuser holds the mode
// (tick, accept size, cancel size, toggle axis), tdata the button level,
// encoder delta, display flag and both axis busy flags. Every item gives
// exactly one rsp item with the move request and the current size and axis.
// The csr channel writes the eight steps-per-pulse registers (Z sizes 0..3 at
// index 0..3, X sizes 0..3 at index 4..7); higher indexes are ignored, and
// csr_ready is always high. Write registers only while no item is in flight.
//
// An item is captured in an input register, then the state update, table
// lookup and one 16 x 15 multiply happen in a single step into the result
// register, which drives rsp_tvalid; one item is taken every cycle while
// rsp_tready is high.
// When rsp_tready is low the result register holds, the input register fills,
// and req_tready then drops until the result is taken.
// Synchronous reset clears the table, the debounce machine, the size indices,
// the axis and the pulse total, and empties both registers.
module handwheel_jog_controller #(
   parameter int DEBOUNCE_TICKS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] button_level, [8:1] encoder_delta, [9] display_active,
   // [10] z_busy, [11] x_busy, [15:12] zero
   input  logic [15:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] move_valid, [1] move_axis, [2] move_reverse, [33:3] move_steps,
   // [34] size_change_shown, [36:35] pending_size, [38:37] active_size,
   // [39] active_axis
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [hjc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);
   import hjc_pkg::*;

   localparam int CNT_W = $clog2(DEBOUNCE_TICKS + 1);

   logic [15:0]        table_ff [8];

   logic               a_valid_ff;
   logic               a_valid_in;
   logic [1:0]         a_mode_ff;
   req_data_type       a_data_ff;
   logic               b_valid_ff;
   logic               b_valid_in;
   rsp_data_type       b_data_ff;

   hjc_state_type      state_ff;
   hjc_state_type      state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   rsp_data_type       step_rsp;

   logic               b_free;
   logic               a_fire;
   logic               req_fire;

   assign csr_ready  = 1'b1;
   assign b_free     = ~b_valid_ff | rsp_tready;
   assign a_fire     = a_valid_ff & b_free;
   assign req_tready = ~a_valid_ff | b_free;
   assign req_fire   = req_tvalid & req_tready;
   assign a_valid_in = req_fire | (a_valid_ff & ~a_fire);
   assign b_valid_in = a_fire | (b_valid_ff & ~rsp_tready);

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_data_ff;

   hjc_step #(
      .DEBOUNCE_TICKS(DEBOUNCE_TICKS),
      .CNT_W(CNT_W)
   ) u_step (
      .mode(a_mode_ff),
      .req(a_data_ff),
      .state(state_ff),
      .cnt(cnt_ff),
      .coeff(table_ff[{state_ff.axis_select, state_ff.current_index}]),
      .state_next(state_in),
      .cnt_next(cnt_in),
      .rsp(step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            table_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready && !csr_index[CSR_INDEX_W-1]) begin
         table_ff[csr_index[2:0]] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         state_ff   <= '0;
         cnt_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         if (a_fire) begin
            state_ff <= state_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_mode_ff <= req_tuser;
         a_data_ff <= req_tdata[REQ_DATA_W-1:0];
      end
      if (a_fire) begin
         b_data_ff <= step_rsp;
      end
   end

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.pulse_total != 16'sh8000)
      else $error("pulse total left its saturation range");

   a_move_clears: assert property (@(posedge clock) disable iff (reset)
      a_fire && step_rsp.move_valid |=> state_ff.pulse_total == '0)
      else $error("pulse total kept after a move");

   a_shown_phase: assert property (@(posedge clock) disable iff (reset)
      a_fire && step_rsp.size_change_shown |=> state_ff.phase == PHASE_WAIT_RELEASE)
      else $error("size change without waiting for release");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEBOUNCE_TICKS))
      else $error("debounce counter above its load value");

   a_toggle_clears: assert property (@(posedge clock) disable iff (reset)
      a_fire && a_mode_ff == MODE_TOGGLE
      |=> state_ff.pending_index == '0 && state_ff.current_index == '0)
      else $error("axis toggle kept a size index");

endmodule
